// ----- hdl/rgbob_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbob_pkg
// Shared widths, register indexes and item types of the RGBA blender.
// ----------------------------------------------------------------------------
package rgbob_pkg;

   localparam int FIELD_W = 13;
   localparam int NUM_COLORS = 3;
   localparam int FRAC_BITS_DEF = 12;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_PRESENT = 1'b1;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_OVER = 1'b1;

   typedef logic [FIELD_W-1:0] field_type;

   localparam field_type FIELD_MAX = '1;

   // One classified pixel. For anything but the over case the result is
   // already complete in res_rgb and res_alpha.
   typedef struct packed {
      logic                           is_over;
      field_type [NUM_COLORS-1:0]     base_rgb;
      field_type                      base_alpha;
      field_type [NUM_COLORS-1:0]     top_rgb;
      field_type                      top_alpha;
      field_type [NUM_COLORS-1:0]     res_rgb;
      field_type                      res_alpha;
   } item_type;

   // What travels beside the divider lanes.
   typedef struct packed {
      logic                           is_over;
      field_type [NUM_COLORS-1:0]     res_rgb;
      field_type                      res_alpha;
   } side_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

// ----- hdl/rgbob_ifs.sv -----
// ----------------------------------------------------------------------------
// rgbob_ifs
// Valid/ready channels for the pixel pair going in and the blended pixel out.
// ----------------------------------------------------------------------------
interface rgbob_req_if;
   logic                valid;
   logic                ready;
   rgbob_pkg::field_type base_red;
   rgbob_pkg::field_type base_green;
   rgbob_pkg::field_type base_blue;
   rgbob_pkg::field_type base_alpha;
   rgbob_pkg::field_type top_red;
   rgbob_pkg::field_type top_green;
   rgbob_pkg::field_type top_blue;
   rgbob_pkg::field_type top_alpha;

   modport source (
      output valid, base_red, base_green, base_blue, base_alpha,
      output top_red, top_green, top_blue, top_alpha,
      input  ready
   );
   modport sink (
      input  valid, base_red, base_green, base_blue, base_alpha,
      input  top_red, top_green, top_blue, top_alpha,
      output ready
   );
endinterface

interface rgbob_rsp_if;
   logic                valid;
   logic                ready;
   rgbob_pkg::field_type out_red;
   rgbob_pkg::field_type out_green;
   rgbob_pkg::field_type out_blue;
   rgbob_pkg::field_type out_alpha;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha,
      output ready
   );
endinterface

// ----- hdl/rgbob_front.sv -----
// ----------------------------------------------------------------------------
// rgbob_front
// Accepts a pixel pair, resolves the effective alphas and sorts the pair into
// the add, top, base or over case. All cases but over are finished here.
// ----------------------------------------------------------------------------
module rgbob_front #(
   parameter int FRAC_BITS = rgbob_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       blend_mode,
   input  logic                       alpha_present,
   rgbob_req_if.sink                  req_chan,
   input  rgbob_pkg::queue_stat_type  q_stat,
   output logic                       push,
   output rgbob_pkg::item_type        item
);

   localparam int FW = rgbob_pkg::FIELD_W;
   localparam int NC = rgbob_pkg::NUM_COLORS;
   localparam int AW = (FRAC_BITS + 1 > FW) ? FRAC_BITS + 1 : FW;
   localparam logic [AW-1:0] UNIT = AW'(1) << FRAC_BITS;

   logic [AW-1:0]                    ba_eff;
   logic [AW-1:0]                    ta_eff;
   logic [AW:0]                      alpha_sum;
   logic [AW:0]                      alpha_clamp;
   logic [FW:0]                      color_sum;
   rgbob_pkg::field_type [NC-1:0]    bc;
   rgbob_pkg::field_type [NC-1:0]    tc;
   rgbob_pkg::item_type              item_in;
   rgbob_pkg::item_type              item_ff;
   logic                             valid_in;
   logic                             valid_ff;
   logic                             take;

   always_comb begin
      bc[0] = req_chan.base_red;
      bc[1] = req_chan.base_green;
      bc[2] = req_chan.base_blue;
      tc[0] = req_chan.top_red;
      tc[1] = req_chan.top_green;
      tc[2] = req_chan.top_blue;
      ba_eff = alpha_present ? AW'(req_chan.base_alpha) : UNIT;
      ta_eff = alpha_present ? AW'(req_chan.top_alpha) : UNIT;

      alpha_sum = {1'b0, ba_eff} + {1'b0, ta_eff};
      alpha_clamp = (alpha_sum > {1'b0, UNIT}) ? {1'b0, UNIT} : alpha_sum;
      color_sum = '0;

      item_in.is_over = 1'b0;
      item_in.base_rgb = bc;
      item_in.base_alpha = req_chan.base_alpha;
      item_in.top_rgb = tc;
      item_in.top_alpha = req_chan.top_alpha;
      item_in.res_rgb = bc;
      item_in.res_alpha = ba_eff[FW-1:0];

      if (blend_mode == rgbob_pkg::MODE_ADD) begin
         for (int i = 0; i < NC; i++) begin
            color_sum = {1'b0, bc[i]} + {1'b0, tc[i]};
            item_in.res_rgb[i] = color_sum[FW] ? rgbob_pkg::FIELD_MAX : color_sum[FW-1:0];
         end
         item_in.res_alpha = alpha_clamp[FW-1:0];
      end else if (ta_eff >= UNIT || ba_eff == '0) begin
         item_in.res_rgb = tc;
         item_in.res_alpha = ta_eff[FW-1:0];
      end else if (ta_eff == '0) begin
         item_in.res_rgb = bc;
         item_in.res_alpha = ba_eff[FW-1:0];
      end else begin
         // A partial top can only happen with alpha present, so the raw
         // alpha fields are the effective ones from here on.
         item_in.is_over = 1'b1;
      end
   end

   assign req_chan.ready = !valid_ff || !q_stat.full;
   assign take = req_chan.valid && req_chan.ready;
   assign push = valid_ff && !q_stat.full;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// ----- hdl/rgbob_queue.sv -----
// ----------------------------------------------------------------------------
// rgbob_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module rgbob_queue #(
   parameter int DEPTH = rgbob_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rgbob_pkg::item_type        wr_item,
   input  logic                       pop,
   output rgbob_pkg::item_type        rd_item,
   output rgbob_pkg::queue_stat_type  q_stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rgbob_pkg::item_type  mem_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff;
   logic [PW-1:0]        wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff;
   logic [PW-1:0]        rd_ptr_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   assign rd_item = mem_ff[rd_ptr_ff];
   assign q_stat.full = (count_ff == CW'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

// ----- hdl/rgbob_div.sv -----
// ----------------------------------------------------------------------------
// rgbob_div
// Pipelined restoring divider, one quotient bit per stage, with one lane per
// color sharing a common divisor.
// ----------------------------------------------------------------------------
module rgbob_div #(
   parameter int NUM_W = 39,
   parameter int DEN_W = 26
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         enable,
   input  logic                                         in_valid,
   input  logic [rgbob_pkg::NUM_COLORS-1:0][NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]                             in_den,
   input  rgbob_pkg::side_type                          in_side,
   output logic                                         out_valid,
   output rgbob_pkg::field_type [rgbob_pkg::NUM_COLORS-1:0] out_quo,
   output rgbob_pkg::side_type                          out_side
);

   localparam int NC = rgbob_pkg::NUM_COLORS;
   localparam int QW = rgbob_pkg::FIELD_W;

   logic                         v_ff    [QW];
   logic [NC-1:0][NUM_W-1:0]     rem_ff  [QW];
   logic [DEN_W-1:0]             den_ff  [QW];
   logic [NC-1:0][QW-1:0]        quo_ff  [QW];
   rgbob_pkg::side_type          side_ff [QW];

   // Stage k settles quotient bit QW-1-k. The dividend is always below the
   // divisor times 2**QW, because the quotient is a weighted mean of colors.
   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int QB = QW - 1 - k;

      logic                      v_prev;
      logic [NC-1:0][NUM_W-1:0]  rem_prev;
      logic [DEN_W-1:0]          den_prev;
      logic [NC-1:0][QW-1:0]     quo_prev;
      rgbob_pkg::side_type       side_prev;
      logic [NUM_W-1:0]          den_shift;
      logic [NC-1:0][NUM_W:0]    diff;
      logic [NC-1:0][NUM_W-1:0]  rem_next;
      logic [NC-1:0][QW-1:0]     quo_next;

      if (k == 0) begin : g_first
         assign v_prev = in_valid;
         assign rem_prev = in_num;
         assign den_prev = in_den;
         assign quo_prev = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev = v_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         den_shift = NUM_W'(den_prev) << QB;
         for (int i = 0; i < NC; i++) begin
            diff[i] = {1'b0, rem_prev[i]} - {1'b0, den_shift};
            rem_next[i] = diff[i][NUM_W] ? rem_prev[i] : diff[i][NUM_W-1:0];
            quo_next[i] = quo_prev[i];
            quo_next[i][QB] = !diff[i][NUM_W];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (enable) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_next;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_next;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_side = side_ff[QW-1];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         out_quo[i] = quo_ff[QW-1][i];
      end
   end

endmodule

// ----- hdl/rgbob_back.sv -----
// ----------------------------------------------------------------------------
// rgbob_back
// Carries out the over rule: weights, numerators and the blended alpha in
// three stages, then the divider. The whole pipe stalls as one when the
// result at its end is not taken.
// ----------------------------------------------------------------------------
module rgbob_back #(
   parameter int FRAC_BITS = rgbob_pkg::FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rgbob_pkg::queue_stat_type  q_stat,
   output logic                       pop,
   input  rgbob_pkg::item_type        item,
   rgbob_rsp_if.source                rsp_chan
);

   localparam int FW  = rgbob_pkg::FIELD_W;
   localparam int NC  = rgbob_pkg::NUM_COLORS;
   localparam int XW  = (FRAC_BITS + 1 > FW) ? FRAC_BITS + 1 : FW;
   localparam int WW  = FRAC_BITS + FW;
   localparam int PTW = 2 * FW;
   localparam int WBW = WW + FW;
   localparam int MX  = (2 * FRAC_BITS > FRAC_BITS + FW) ? 2 * FRAC_BITS : FRAC_BITS + FW;
   localparam int DW  = MX + 1;
   localparam int NW  = DW + FW;
   localparam int AHW = DW - FRAC_BITS;
   localparam logic [XW-1:0] UNIT_X = XW'(1) << FRAC_BITS;

   logic                             adv;
   logic                             last_valid;
   logic [FRAC_BITS-1:0]             one_minus_ta;
   logic [AHW-1:0]                   alpha_hi;
   rgbob_pkg::field_type             alpha_sat;

   // Stage A: weight of the base and top color products.
   logic                             a_valid_ff;
   logic [WW-1:0]                    a_w_ff;
   logic [NC-1:0][PTW-1:0]           a_pt_ff;
   rgbob_pkg::field_type [NC-1:0]    a_bc_ff;
   rgbob_pkg::field_type             a_ta_ff;
   rgbob_pkg::side_type              a_side_ff;

   // Stage B: full alpha and base color products.
   logic                             b_valid_ff;
   logic [DW-1:0]                    b_afull_ff;
   logic [NC-1:0][WBW-1:0]           b_wb_ff;
   logic [NC-1:0][PTW-1:0]           b_pt_ff;
   rgbob_pkg::side_type              b_side_ff;

   // Stage C: numerators, divisor and the final alpha.
   logic                             c_valid_ff;
   logic [NC-1:0][NW-1:0]            c_num_ff;
   logic [DW-1:0]                    c_den_ff;
   rgbob_pkg::side_type              c_side_ff;

   rgbob_pkg::field_type [NC-1:0]    quo;
   rgbob_pkg::side_type              d_side;

   assign adv = !last_valid || rsp_chan.ready;
   assign pop = adv && !q_stat.empty;

   assign one_minus_ta = FRAC_BITS'(UNIT_X - XW'(item.top_alpha));

   assign alpha_hi = b_afull_ff[DW-1:FRAC_BITS];
   assign alpha_sat = (alpha_hi > AHW'(rgbob_pkg::FIELD_MAX)) ? rgbob_pkg::FIELD_MAX
                                                              : alpha_hi[FW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= pop;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_w_ff <= WW'(one_minus_ta) * WW'(item.base_alpha);
         for (int i = 0; i < NC; i++) begin
            a_pt_ff[i] <= PTW'(item.top_alpha) * PTW'(item.top_rgb[i]);
         end
         a_bc_ff <= item.base_rgb;
         a_ta_ff <= item.top_alpha;
         a_side_ff.is_over <= item.is_over;
         a_side_ff.res_rgb <= item.res_rgb;
         a_side_ff.res_alpha <= item.res_alpha;

         b_afull_ff <= (DW'(a_ta_ff) << FRAC_BITS) + DW'(a_w_ff);
         for (int i = 0; i < NC; i++) begin
            b_wb_ff[i] <= WBW'(a_w_ff) * WBW'(a_bc_ff[i]);
         end
         b_pt_ff <= a_pt_ff;
         b_side_ff <= a_side_ff;

         for (int i = 0; i < NC; i++) begin
            c_num_ff[i] <= (NW'(b_pt_ff[i]) << FRAC_BITS) + NW'(b_wb_ff[i]);
         end
         c_den_ff <= b_afull_ff;
         c_side_ff.is_over <= b_side_ff.is_over;
         c_side_ff.res_rgb <= b_side_ff.res_rgb;
         c_side_ff.res_alpha <= b_side_ff.is_over ? alpha_sat : b_side_ff.res_alpha;
      end
   end

   rgbob_div #(
      .NUM_W (NW),
      .DEN_W (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (c_valid_ff),
      .in_num    (c_num_ff),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (last_valid),
      .out_quo   (quo),
      .out_side  (d_side)
   );

   assign rsp_chan.valid = last_valid;
   assign rsp_chan.out_red = d_side.is_over ? quo[0] : d_side.res_rgb[0];
   assign rsp_chan.out_green = d_side.is_over ? quo[1] : d_side.res_rgb[1];
   assign rsp_chan.out_blue = d_side.is_over ? quo[2] : d_side.res_rgb[2];
   assign rsp_chan.out_alpha = d_side.res_alpha;

endmodule

// ----- hdl/rgba_add_or_over_blend.sv -----
// ----------------------------------------------------------------------------
// rgba_add_or_over_blend
// Blends a top RGBA pixel onto a base RGBA pixel, all channels unsigned fixed
// point with FRAC_BITS fraction bits (4096 is 1.0 by default). Add mode sums
// the colors, saturating at 8191, and clamps the summed alpha at 1.0. Over
// mode passes the top pixel when it is opaque or the base is transparent,
// keeps the base when the top is transparent, and otherwise applies the over
// rule with a truncating division by the blended alpha. With alpha_present
// cleared both alphas count as 1.0. The block takes one pixel pair per clock
// while its front register is free or the queue is not full, and passes each
// result through the classifying front register, the queue, three multiply
// and add stages and a thirteen-stage restoring divider. Every pixel takes
// that path so results leave in order. A four-deep queue lets the front keep
// accepting while the output is held. Write the registers only while the
// block is empty.
// ----------------------------------------------------------------------------
module rgba_add_or_over_blend #(
   parameter int FRAC_BITS   = rgbob_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = rgbob_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rgbob_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rgbob_pkg::CSR_DATA_W-1:0]    csr_wdata,
   rgbob_req_if.sink                           req_chan,
   rgbob_rsp_if.source                         rsp_chan
);

   logic                       blend_mode_ff;
   logic                       blend_mode_in;
   logic                       alpha_present_ff;
   logic                       alpha_present_in;
   logic                       push;
   logic                       pop;
   rgbob_pkg::item_type        front_item;
   rgbob_pkg::item_type        back_item;
   rgbob_pkg::queue_stat_type  q_stat;

   always_comb begin
      blend_mode_in = blend_mode_ff;
      alpha_present_in = alpha_present_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rgbob_pkg::CSR_BLEND_MODE:    blend_mode_in = csr_wdata[0];
            rgbob_pkg::CSR_ALPHA_PRESENT: alpha_present_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= rgbob_pkg::MODE_OVER;
         alpha_present_ff <= 1'b1;
      end else begin
         blend_mode_ff <= blend_mode_in;
         alpha_present_ff <= alpha_present_in;
      end
   end

   rgbob_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .blend_mode    (blend_mode_ff),
      .alpha_present (alpha_present_ff),
      .req_chan      (req_chan),
      .q_stat        (q_stat),
      .push          (push),
      .item          (front_item)
   );

   rgbob_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (front_item),
      .pop     (pop),
      .rd_item (back_item),
      .q_stat  (q_stat)
   );

   rgbob_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop      (pop),
      .item     (back_item),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // Both registers come out of reset selecting over mode with alpha.
   a_csr_reset: assert property (@(posedge clock)
      $past(reset) |-> ((blend_mode_ff == rgbob_pkg::MODE_OVER) && alpha_present_ff))
      else $error("blend registers not at their reset values after reset");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("queue read while empty");

   a_stat_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty at once");
`endif

endmodule
